// ----- rtl/box_downscale_2x2_core_defines.svh -----
// ----------------------------------------------------------------------------
// box_downscale_2x2_core_defines
// assertion macros for the 2x2 box downscaler; empty bodies under synthesis
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSCALE_2X2_CORE_DEFINES_SVH
`define BOX_DOWNSCALE_2X2_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/bds2x2_pkg.sv -----
// ----------------------------------------------------------------------------
// bds2x2_pkg
// widths, register indexes and pixel types of the 2x2 box downscaler
// ----------------------------------------------------------------------------
`default_nettype none
package bds2x2_pkg;
	localparam int PIX_W     = 8;
	localparam int LANE_W    = 9;
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int STORE_W   = 3 * LANE_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_MAX          = 13'h1FFF;
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgb_t;

	// horizontal pair sums, red in the low lane
	typedef struct packed {
		logic [LANE_W-1:0] blue;
		logic [LANE_W-1:0] green;
		logic [LANE_W-1:0] red;
	} pair_sum_t;
endpackage
`default_nettype wire

// ----- rtl/box_downscale_2x2_core.sv -----
// ----------------------------------------------------------------------------
// box_downscale_2x2_core
// 2x2 box-filter downscaler for a raster-order RGB pixel stream
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order and emits one pixel per 2x2
// block, each channel the truncated mean of the four. Rate: one pixel per
// cycle sustained while the output is taken; a result passes through stage 1
// and then the output register after the odd-row, odd-column pixel that
// completes it is taken, and the input stalls only while a result waits in
// stage 1 behind an output that is held off. The even row's horizontal pair
// sums live in a single-port-per-side line memory of (MAX_WIDTH+1)/2 entries
// with a registered read; the odd row reads the entry written one full row
// earlier, so reads and writes of an entry never overlap. An odd last column
// or row is dropped. frame_done marks the last result of a frame. Writing
// frame_width or frame_height restarts the frame; a width of 0 acts as 1 and
// widths above MAX_WIDTH are clamped to it.
// No clearing pass after reset: the memory is always written before read.
`default_nettype none
`include "box_downscale_2x2_core_defines.svh"
module box_downscale_2x2_core
	import bds2x2_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	// pixel input
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [PIX_W-1:0]     in_red,
	input  wire logic [PIX_W-1:0]     in_green,
	input  wire logic [PIX_W-1:0]     in_blue,
	// downscaled output
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PIX_W-1:0]          out_red,
	output logic [PIX_W-1:0]          out_green,
	output logic [PIX_W-1:0]          out_blue,
	output logic                      frame_done
);
	// line memory geometry
	localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	// the width register cannot exceed its own 13 bits
	localparam int WIDTH_CAP   = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;

	// zero acts as one, large widths clamp at the line capacity
	function automatic logic [DIM_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] cap;
		cap = DIM_W'(WIDTH_CAP);
		if (v == '0)
			return DIM_W'(1);
		else if (v > cap)
			return cap;
		else
			return v;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
		return (v == '0) ? DIM_W'(1) : v;
	endfunction

	// effective frame size
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	// raster position of the next pixel
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	// even-column pixel waiting for its partner
	rgb_t             even_px_q;

	// stage 1: memory read in flight
	logic             valid_s1;
	pair_sum_t        pair_s1;
	logic             done_s1;
	pair_sum_t        above_s1;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] red_q;
	logic [PIX_W-1:0] green_q;
	logic [PIX_W-1:0] blue_q;
	logic             done_q;

	// line memory of even-row pair sums
	pair_sum_t        line_mem [STORE_DEPTH];

	rgb_t             px;
	pair_sum_t        pair_now;
	logic             accept;
	logic             out_free;
	logic             col_odd;
	logic             row_odd;
	logic             col_last;
	logic             row_last;
	logic             row_has_next;
	logic             last_block;
	logic             mem_wr;
	logic             mem_rd;
	logic [ADDR_W-1:0] slot;
	logic [LANE_W:0]  sum_red;
	logic [LANE_W:0]  sum_green;
	logic [LANE_W:0]  sum_blue;

	// handshake: output register frees up when empty or being taken
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || out_free;
	assign accept   = in_valid && in_ready;

	assign px.red   = in_red;
	assign px.green = in_green;
	assign px.blue  = in_blue;

	// pair sum of the current odd-column pixel and its even partner
	assign pair_now.red   = {1'b0, px.red}   + {1'b0, even_px_q.red};
	assign pair_now.green = {1'b0, px.green} + {1'b0, even_px_q.green};
	assign pair_now.blue  = {1'b0, px.blue}  + {1'b0, even_px_q.blue};

	assign col_odd = col_q[0];
	assign row_odd = row_q[0];
	assign slot    = ADDR_W'(col_q >> 1);

	// position tests done one bit wider so nothing wraps
	assign col_last     = ({1'b0, col_q} + 14'd1) >= {1'b0, width_q};
	assign row_last     = ({1'b0, row_q} + 14'd1) >= {1'b0, height_q};
	assign row_has_next = !row_last;
	// last complete 2x2 block: position one short of the even-rounded size
	assign last_block   = (({1'b0, row_q} + 14'd1) == {1'b0, height_q[DIM_W-1:1], 1'b0}) &&
	                      (({1'b0, col_q} + 14'd1) == {1'b0, width_q[DIM_W-1:1], 1'b0});

	// even row stores pair sums unless no odd row follows; odd row reads them
	assign mem_wr = accept && col_odd && !row_odd && row_has_next;
	assign mem_rd = accept && col_odd && row_odd;

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_width(FRAME_WIDTH_RST);
			height_q <= clamp_height(FRAME_HEIGHT_RST);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we && (cfg_index == CFG_FRAME_WIDTH)) begin
			width_q <= clamp_width(cfg_data);
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_we && (cfg_index == CFG_FRAME_HEIGHT)) begin
			height_q <= clamp_height(cfg_data);
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + DIM_W'(1);
			end else begin
				col_q <= col_q + DIM_W'(1);
			end
		end
	end

	// hold the even-column pixel for the pair add
	always_ff @(posedge clk) begin
		if (accept && !col_odd)
			even_px_q <= px;
	end

	// line memory: registered read, write a full row ahead of the read
	always_ff @(posedge clk) begin
		if (mem_wr)
			line_mem[slot] <= pair_now;
		if (mem_rd)
			above_s1 <= line_mem[slot];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mem_rd) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (mem_rd) begin
			pair_s1 <= pair_now;
			done_s1 <= last_block;
		end
	end

	// four-pixel totals, 10 bits per lane
	assign sum_red   = {1'b0, above_s1.red}   + {1'b0, pair_s1.red};
	assign sum_green = {1'b0, above_s1.green} + {1'b0, pair_s1.green};
	assign sum_blue  = {1'b0, above_s1.blue}  + {1'b0, pair_s1.blue};

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output payload: divide by four, truncating
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			red_q   <= sum_red[LANE_W:2];
			green_q <= sum_green[LANE_W:2];
			blue_q  <= sum_blue[LANE_W:2];
			done_q  <= done_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = red_q;
	assign out_green  = green_q;
	assign out_blue   = blue_q;
	assign frame_done = done_q;

	// a blocked stage 1 must stall the input
	`BDS_ASSERT_IMPLY(a_stall_input, clk, arst_n, valid_s1 && !out_free, !in_ready,
		"input taken while stage 1 is blocked")
	// a blocked stage 1 keeps its result
	`BDS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !out_free, valid_s1,
		"stage 1 result lost while blocked")
	// every odd-row odd-column pixel yields a stage 1 result
	`BDS_ASSERT_NEXT(a_s1_load, clk, arst_n, accept && col_odd && row_odd, valid_s1,
		"odd block pixel produced no result")
	// raster wraps to the origin after the frame's last pixel
	`BDS_ASSERT_NEXT(a_frame_wrap, clk, arst_n,
		accept && !cfg_we && col_last && row_last, (col_q == '0) && (row_q == '0),
		"raster position did not wrap at frame end")
endmodule
`default_nettype wire

// ----- test/box_downscale_2x2_core_test.sv -----
// ----------------------------------------------------------------------------
// box_downscale_2x2_core_test
// self-checking bench for the 2x2 box downscaler: drives raster pixels over
// valid/ready, predicts every averaged pixel and its frame_done flag from a
// behavioral copy of the line store, and checks results in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module box_downscale_2x2_core_test;
	import bds2x2_pkg::*;

	localparam int MAX_WIDTH     = 4096;
	localparam int RANDOM_PIXELS = 450;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT  = 10;
	localparam longint RUN_LIMIT_NS = 10_000_000;

	// index that maps to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		rgb_t pix;
		logic done;
	} scaled_px_t;

	// clock, reset and block inputs, all known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic [PIX_W-1:0]     in_red    = '0;
	logic [PIX_W-1:0]     in_green  = '0;
	logic [PIX_W-1:0]     in_blue   = '0;
	logic                 out_ready = 1'b0;

	logic             in_ready;
	logic             out_valid;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic             frame_done;

	// idle rates in percent, and the long receiver hold-off in cycles
	int src_gap_pct    = 20;
	int sink_stall_pct = 20;
	int sink_hold      = 0;

	// run statistics
	int pixels_sent    = 0;
	int scaled_checked = 0;
	int reg_writes     = 0;
	int mismatch_count = 0;

	// behavioral copy of the downscaler: geometry, raster position, the
	// running horizontal pair sum and the even-row pair sums
	logic [DIM_W-1:0] geom_width  = FRAME_WIDTH_RST;
	logic [DIM_W-1:0] geom_height = FRAME_HEIGHT_RST;
	logic [DIM_W-1:0] col_pos     = '0;
	logic [DIM_W-1:0] row_pos     = '0;
	pair_sum_t        run_pair    = '0;
	pair_sum_t        upper_pairs [MAX_WIDTH/2] = '{default: '0};

	// averaged pixels still owed by the block, oldest first
	scaled_px_t awaited_scaled [$];

	box_downscale_2x2_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_done (frame_done)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// advance the raster by one accepted pixel; queue an averaged pixel when
	// it closes a 2x2 block on an odd row
	task automatic predict_downscale(input rgb_t px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		pair_sum_t   above;
		scaled_px_t  avg;
		w = geom_width;
		h = geom_height;
		c = col_pos;
		r = row_pos;
		// a zero dimension acts as one, an oversized width is clamped
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h == 0) h = 1;
		if (c % 2 == 0) begin
			run_pair.red   = LANE_W'(px.red);
			run_pair.green = LANE_W'(px.green);
			run_pair.blue  = LANE_W'(px.blue);
		end else begin
			// lanes top out at 510, no carry between them
			run_pair.red   = run_pair.red + LANE_W'(px.red);
			run_pair.green = run_pair.green + LANE_W'(px.green);
			run_pair.blue  = run_pair.blue + LANE_W'(px.blue);
			if (r % 2 == 0) begin
				// an even last row of an odd-height frame is never stored
				if (r + 1 < h) upper_pairs[c / 2] = run_pair;
			end else begin
				above         = upper_pairs[c / 2];
				avg.pix.red   = PIX_W'((11'(above.red) + 11'(run_pair.red)) >> 2);
				avg.pix.green = PIX_W'((11'(above.green) + 11'(run_pair.green)) >> 2);
				avg.pix.blue  = PIX_W'((11'(above.blue) + 11'(run_pair.blue)) >> 2);
				// last full block: odd last column or row is dropped
				avg.done = (r == (h & 32'hFFFF_FFFE) - 1) &&
					(c == (w & 32'hFFFF_FFFE) - 1);
				awaited_scaled.push_back(avg);
			end
		end
		if (c + 1 >= w) begin
			col_pos = '0;
			row_pos = (r + 1 >= h) ? '0 : DIM_W'(r + 1);
		end else begin
			col_pos = DIM_W'(c + 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// one register write; the caller makes sure the block is idle
	task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// only the two geometry registers restart the frame
		if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
			if (idx == CFG_FRAME_WIDTH) geom_width = val;
			else geom_height = val;
			col_pos = '0;
			row_pos = '0;
		end
		reg_writes++;
		// keeps a following write from landing in the same step
		@(posedge clk);
	endtask

	// offer one pixel request, with random gaps, and predict on acceptance;
	// valid stays high on return so back-to-back requests need no toggle
	task automatic send_pixel(input rgb_t px);
		if ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
		end
		in_valid <= 1'b1;
		in_red   <= px.red;
		in_green <= px.green;
		in_blue  <= px.blue;
		do @(posedge clk); while (!in_ready);
		predict_downscale(px);
		pixels_sent++;
	endtask

	// stop offering, wait for every owed result, then let the pipe empty
	task automatic drain_scaled();
		in_valid <= 1'b0;
		while (awaited_scaled.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic rgb_t random_pixel();
		rgb_t px;
		px = 24'($urandom);
		// a quarter of the pixels sit on the channel extremes
		if ($urandom_range(3) == 0) begin
			px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
			px.green = $urandom_range(1) ? 8'hFF : 8'h00;
			px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return px;
	endfunction

	function automatic rgb_t flat_pixel(input logic [PIX_W-1:0] level);
		rgb_t px;
		px.red   = level;
		px.green = level;
		px.blue  = level;
		return px;
	endfunction

	task automatic send_random_pixels(input int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off counted down here
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// checker: every accepted result against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		scaled_px_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_scaled.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unexpected output pixel r=%0d g=%0d b=%0d done=%0b",
						$realtime, out_red, out_green, out_blue, frame_done);
			end else begin
				want = awaited_scaled.pop_front();
				scaled_checked++;
				if (out_red !== want.pix.red || out_green !== want.pix.green ||
						out_blue !== want.pix.blue || frame_done !== want.done) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"%0t: output pixel %0d: expected r=%0d g=%0d b=%0d",
							" done=%0b, got r=%0d g=%0d b=%0d done=%0b"},
							$realtime, scaled_checked, want.pix.red, want.pix.green,
							want.pix.blue, want.done, out_red, out_green, out_blue,
							frame_done);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset geometry 640x480: one full even row, then the head of the odd row
	task automatic test_reset_geometry();
		send_random_pixels(640 + 40);
		drain_scaled();
	endtask

	// smallest frames, channel extremes, zero and one dimensions, odd edges
	task automatic test_corner_frames();
		rgb_t mixed [4];
		// 2x2 frames: all-ones block, then all-zeros after the frame wraps
		write_geometry(CFG_FRAME_WIDTH, 13'd2);
		write_geometry(CFG_FRAME_HEIGHT, 13'd2);
		repeat (4) send_pixel(flat_pixel(8'hFF));
		repeat (4) send_pixel(flat_pixel(8'h00));
		drain_scaled();
		// zero width acts as one column: never a result
		write_geometry(CFG_FRAME_WIDTH, 13'd0);
		send_random_pixels(2);
		drain_scaled();
		// zero height acts as one row: never a result
		write_geometry(CFG_FRAME_WIDTH, 13'd3);
		write_geometry(CFG_FRAME_HEIGHT, 13'd0);
		send_random_pixels(3);
		drain_scaled();
		// 3x3: last column and last row dropped, one block that ends the frame
		write_geometry(CFG_FRAME_HEIGHT, 13'd3);
		send_random_pixels(9);
		drain_scaled();
		// a write to an unmapped index leaves the frame position alone
		mixed[0] = '{blue: 8'h01, green: 8'h00, red: 8'hFF};
		mixed[1] = '{blue: 8'h02, green: 8'hFF, red: 8'h00};
		mixed[2] = '{blue: 8'hFF, green: 8'h01, red: 8'h03};
		mixed[3] = '{blue: 8'hFF, green: 8'hFE, red: 8'h02};
		write_geometry(CFG_FRAME_WIDTH, 13'd4);
		write_geometry(CFG_FRAME_HEIGHT, 13'd2);
		send_pixel(mixed[0]);
		send_pixel(mixed[1]);
		drain_scaled();
		write_geometry(CFG_SPARE, 13'h1FFF);
		send_pixel(mixed[2]);
		send_pixel(mixed[3]);
		foreach (mixed[i]) send_pixel(mixed[i]);
		drain_scaled();
	endtask

	// largest height register value: rows go on, frame_done never comes
	task automatic test_tall_frame();
		write_geometry(CFG_FRAME_WIDTH, 13'd2);
		write_geometry(CFG_FRAME_HEIGHT, DIM_MAX);
		send_random_pixels(8);
		drain_scaled();
	endtask

	// two full rows back to back: the long stretch with no idling on
	// either side
	task automatic test_unbroken_rows();
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		write_geometry(CFG_FRAME_WIDTH, 13'd256);
		write_geometry(CFG_FRAME_HEIGHT, 13'd2);
		send_random_pixels(2 * 256);
		drain_scaled();
		src_gap_pct    = 20;
		sink_stall_pct = 20;
	endtask

	// output held off long enough to fill the block and stall the input;
	// then a sender pause mid-frame until every result is in
	task automatic test_backpressure();
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		write_geometry(CFG_FRAME_WIDTH, 13'd4);
		write_geometry(CFG_FRAME_HEIGHT, 13'd4);
		sink_hold = 150;
		send_random_pixels(64);
		drain_scaled();
		src_gap_pct    = 20;
		sink_stall_pct = 20;
		write_geometry(CFG_FRAME_WIDTH, 13'd6);
		send_random_pixels(12);
		drain_scaled();
		send_random_pixels(12);
		drain_scaled();
	endtask

	// random geometry per phase, full or cut-short frames, random content
	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int frame_px;
		int count;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(19))
				0:       w = 0;
				1:       w = $urandom_range(13, 40);
				default: w = $urandom_range(1, 12);
			endcase
			case ($urandom_range(19))
				0:       h = 0;
				1:       h = $urandom_range(9, 20);
				default: h = $urandom_range(1, 8);
			endcase
			// sometimes only one register moves; either write restarts the frame
			case ($urandom_range(3))
				0: write_geometry(CFG_FRAME_WIDTH, DIM_W'(w));
				1: write_geometry(CFG_FRAME_HEIGHT, DIM_W'(h));
				2: begin
					write_geometry(CFG_FRAME_HEIGHT, DIM_W'(h));
					write_geometry(CFG_FRAME_WIDTH, DIM_W'(w));
				end
				default: begin
					write_geometry(CFG_FRAME_WIDTH, DIM_W'(w));
					write_geometry(CFG_FRAME_HEIGHT, DIM_W'(h));
				end
			endcase
			frame_px = (geom_width == 0 ? 1 : int'(geom_width)) *
				(geom_height == 0 ? 1 : int'(geom_height));
			if ($urandom_range(9) < 7) count = frame_px * $urandom_range(1, 2);
			else count = $urandom_range(1, frame_px);
			if (count > 300) count = 300;
			send_random_pixels(count);
			drain_scaled();
			sent += count;
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_corner_frames();
		test_tall_frame();
		test_unbroken_rows();
		test_backpressure();
		test_random_frames();
		drain_scaled();

		$display("covered %0d pixels, %0d downscaled pixels checked, %0d register writes",
			pixels_sent, scaled_checked, reg_writes);
		$display("geometry from zero and one up to 8191-row frames, odd edges, held-off output");
		if (mismatch_count == 0 && awaited_scaled.size() == 0) begin
			$display("box_downscale_2x2_core_test passed");
		end else begin
			$display("box_downscale_2x2_core_test failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#(RUN_LIMIT_NS);
		$display("box_downscale_2x2_core_test failed");
		$finish;
	end
endmodule
